[hw/rtl/pgrw_pkg.sv]
package pgrw_pkg;

    localparam int ROBOT_COUNT_DEF = 4;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;

    localparam logic [6:0]  GRID_ROWS_RST     = 7'd64;
    localparam logic [6:0]  GRID_COLS_RST     = 7'd64;
    localparam logic [15:0] EVAP_RATE_RST     = 16'd6554;
    localparam logic [15:0] NEIGHBOR_GAIN_RST = 16'd14300;
    localparam logic [15:0] OWN_GAIN_RST      = 16'd42598;

    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_EVAP  = 2'd2,
        CMD_NOP   = 2'd3
    } pgrw_cmd_t;

    typedef enum logic [2:0] {
        REG_GRID_ROWS     = 3'd0,
        REG_GRID_COLS     = 3'd1,
        REG_EVAP_RATE     = 3'd2,
        REG_NEIGHBOR_GAIN = 3'd3,
        REG_OWN_GAIN      = 3'd4
    } pgrw_reg_t;

    typedef enum logic [1:0] {
        KIND_NB  = 2'd0,
        KIND_OWN = 2'd1,
        KIND_EV  = 2'd2
    } pgrw_kind_t;

endpackage

[hw/rtl/pheromone_grid_robot_walker_unit.sv]
// channel   | signals                          | payload
// ----------+----------------------------------+------------------------------------------
// command   | s_tvalid s_tready s_tdata s_tuser | tuser cmd, tdata robot, row, col, draw
// result    | m_tvalid m_tready m_tdata          | tdata robot_row, robot_col, count
// config    | cfg_we cfg_index cfg_data          | register write, no read-back
//
// after reset the pheromone memory is swept to zero
// move updates each interior neighbour and then the own cell through one read-modify-write
// path, and the roulette that picks the next position shares its multiplier
// evaporate scales each interior cell of the robot's layer, one memory read and write per cell
// one transaction at a time; a finished result waits in the output register
module pheromone_grid_robot_walker_unit #(
    parameter int ROBOT_COUNT = pgrw_pkg::ROBOT_COUNT_DEF,
    parameter int MAX_ROWS    = pgrw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = pgrw_pkg::MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // robot_index, place_row, place_col, random_fraction
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // robot_row, robot_col, candidate_count
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pgrw_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RBW   = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int DEPTH = ROBOT_COUNT * CELLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = 10;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NB, S_EV, S_RD, S_MUL, S_WR, S_TGT, S_ROUL, S_DONE
    } state_t;

    state_t            state_reg;
    logic [6:0]        grid_rows_reg, grid_cols_reg;
    logic [15:0]       evap_rate_reg, neighbor_gain_reg, own_gain_reg;
    logic [RW-1:0]     pos_row_reg [ROBOT_COUNT];
    logic [CW-1:0]     pos_col_reg [ROBOT_COUNT];
    pgrw_cmd_t         cmd_reg;
    logic [1:0]        rb_reg;
    logic              bad_reg;
    logic [5:0]        prow_reg, pcol_reg;
    logic [15:0]       u_reg;
    logic [AW-1:0]     addr_reg;
    pgrw_kind_t        kind_reg;
    logic [1:0]        dri_reg, dci_reg;
    logic [3:0]        count_reg;
    logic [2:0]        j_reg;
    logic [19:0]       sum_reg, cum_reg;
    logic [16:0]       w_reg [8];
    logic [RW-1:0]     nr_reg [8];
    logic [CW-1:0]     nc_reg [8];
    logic [RW-1:0]     er_reg;
    logic [CW-1:0]     ec_reg;
    logic [35:0]       prod_reg;
    logic [15:0]       rdata_reg;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic [15:0]       mem [DEPTH];

    logic [XW-1:0]     rows_x, cols_x;
    logic [RW-1:0]     rows_m2, r0, place_r;
    logic [CW-1:0]     cols_m2, c0, place_c;
    logic [RBW-1:0]    rbi;
    logic [RW+1:0]     nrow_w;
    logic [CW+1:0]     ncol_w;
    logic              nb_ok, own_ok;
    logic [19:0]       mul_a;
    logic [15:0]       mul_b;
    logic [15:0]       new_val;
    logic [16:0]       new_w;
    logic [19:0]       cum_next;
    logic              hit, last;
    logic              mem_we;
    logic [15:0]       mem_wdata;
    logic              out_load;

    function automatic logic [AW-1:0] addr_of(input logic [RBW-1:0] rb,
                                              input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
        return AW'(AW'(rb) * AW'(CELLS) + AW'(r) * AW'(MAX_COLS) + AW'(c));
    endfunction

    always_comb
    begin
        if (XW'(grid_rows_reg) < XW'(3))
            rows_x = XW'(3);
        else if (XW'(grid_rows_reg) > XW'(MAX_ROWS))
            rows_x = XW'(MAX_ROWS);
        else
            rows_x = XW'(grid_rows_reg);
        if (XW'(grid_cols_reg) < XW'(3))
            cols_x = XW'(3);
        else if (XW'(grid_cols_reg) > XW'(MAX_COLS))
            cols_x = XW'(MAX_COLS);
        else
            cols_x = XW'(grid_cols_reg);
    end

    assign rows_m2 = RW'(rows_x - XW'(2));
    assign cols_m2 = CW'(cols_x - XW'(2));
    assign rbi     = RBW'(rb_reg);
    assign r0      = pos_row_reg[rbi];
    assign c0      = pos_col_reg[rbi];

    always_comb
    begin
        if (prow_reg == 6'd0)
            place_r = RW'(1);
        else if (XW'(prow_reg) > XW'(rows_m2))
            place_r = rows_m2;
        else
            place_r = RW'(prow_reg);
        if (pcol_reg == 6'd0)
            place_c = CW'(1);
        else if (XW'(pcol_reg) > XW'(cols_m2))
            place_c = cols_m2;
        else
            place_c = CW'(pcol_reg);
    end

    // neighbour coordinates, a step below zero wraps high and fails the bound
    assign nrow_w = (RW+2)'(r0) + (RW+2)'(dri_reg) - (RW+2)'(1);
    assign ncol_w = (CW+2)'(c0) + (CW+2)'(dci_reg) - (CW+2)'(1);
    assign nb_ok  = !(dri_reg == 2'd1 && dci_reg == 2'd1)
                    && nrow_w >= (RW+2)'(1) && nrow_w <= (RW+2)'(rows_m2)
                    && ncol_w >= (CW+2)'(1) && ncol_w <= (CW+2)'(cols_m2);
    assign own_ok = r0 >= RW'(1) && r0 <= rows_m2 && c0 >= CW'(1) && c0 <= cols_m2;

    // shared multiplier operands
    always_comb
    begin
        if (state_reg == S_TGT)
        begin
            mul_a = sum_reg;
            mul_b = u_reg;
        end
        else if (kind_reg == KIND_EV)
        begin
            mul_a = 20'(rdata_reg);
            mul_b = evap_rate_reg;
        end
        else
        begin
            mul_a = 20'(17'h10000 - 17'(rdata_reg));
            mul_b = (kind_reg == KIND_OWN) ? own_gain_reg : neighbor_gain_reg;
        end
    end

    assign new_val   = (kind_reg == KIND_EV) ? rdata_reg - prod_reg[31:16]
                                             : rdata_reg + prod_reg[31:16];
    assign new_w     = 17'h10000 - 17'(new_val);
    assign cum_next  = cum_reg + 20'(w_reg[j_reg]);
    assign hit       = {cum_next, 16'h0000} >= prod_reg;
    assign last      = (4'(j_reg) + 4'd1) == count_reg;
    assign mem_we    = state_reg == S_CLEAR || state_reg == S_WR;
    assign mem_wdata = (state_reg == S_CLEAR) ? 16'h0000 : new_val;
    assign out_load  = state_reg == S_DONE && !(cmd_reg == CMD_PLACE && !bad_reg)
                       && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL || state_reg == S_TGT)
            prod_reg <= 36'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg     <= GRID_ROWS_RST;
            grid_cols_reg     <= GRID_COLS_RST;
            evap_rate_reg     <= EVAP_RATE_RST;
            neighbor_gain_reg <= NEIGHBOR_GAIN_RST;
            own_gain_reg      <= OWN_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_ROWS:     grid_rows_reg     <= cfg_data[6:0];
                REG_GRID_COLS:     grid_cols_reg     <= cfg_data[6:0];
                REG_EVAP_RATE:     evap_rate_reg     <= cfg_data;
                REG_NEIGHBOR_GAIN: neighbor_gain_reg <= cfg_data;
                REG_OWN_GAIN:      own_gain_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            count_reg    <= 4'd0;
            for (int i = 0; i < ROBOT_COUNT; i++)
            begin
                pos_row_reg[i] <= '0;
                pos_col_reg[i] <= '0;
            end
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= pgrw_cmd_t'(s_tuser);
                        rb_reg    <= s_tdata[1:0];
                        prow_reg  <= s_tdata[7:2];
                        pcol_reg  <= s_tdata[13:8];
                        u_reg     <= s_tdata[29:14];
                        bad_reg   <= int'(s_tdata[1:0]) >= ROBOT_COUNT;
                        count_reg <= 4'd0;
                        sum_reg   <= 20'd0;
                        dri_reg   <= 2'd0;
                        dci_reg   <= 2'd0;
                        er_reg    <= RW'(1);
                        ec_reg    <= CW'(1);
                        if (int'(s_tdata[1:0]) >= ROBOT_COUNT)
                            state_reg <= S_DONE;
                        else
                        begin
                            unique case (pgrw_cmd_t'(s_tuser))
                                CMD_MOVE: state_reg <= S_NB;
                                CMD_EVAP: state_reg <= S_EV;
                                default:  state_reg <= S_DONE;
                            endcase
                        end
                    end
                end
                S_NB:
                begin
                    if (dri_reg == 2'd3)
                    begin
                        if (own_ok)
                        begin
                            kind_reg  <= KIND_OWN;
                            addr_reg  <= addr_of(rbi, r0, c0);
                            state_reg <= S_RD;
                        end
                        else if (count_reg != 4'd0)
                            state_reg <= S_TGT;
                        else
                            state_reg <= S_DONE;
                    end
                    else if (nb_ok)
                    begin
                        kind_reg  <= KIND_NB;
                        addr_reg  <= addr_of(rbi, RW'(nrow_w), CW'(ncol_w));
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        if (dci_reg == 2'd2)
                        begin
                            dci_reg <= 2'd0;
                            dri_reg <= dri_reg + 2'd1;
                        end
                        else
                            dci_reg <= dci_reg + 2'd1;
                    end
                end
                S_EV:
                begin
                    kind_reg  <= KIND_EV;
                    addr_reg  <= addr_of(rbi, er_reg, ec_reg);
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_WR;
                S_WR:
                begin
                    unique case (kind_reg)
                        KIND_NB:
                        begin
                            w_reg[count_reg[2:0]]  <= new_w;
                            nr_reg[count_reg[2:0]] <= RW'(nrow_w);
                            nc_reg[count_reg[2:0]] <= CW'(ncol_w);
                            sum_reg   <= sum_reg + 20'(new_w);
                            count_reg <= count_reg + 4'd1;
                            if (dci_reg == 2'd2)
                            begin
                                dci_reg <= 2'd0;
                                dri_reg <= dri_reg + 2'd1;
                            end
                            else
                                dci_reg <= dci_reg + 2'd1;
                            state_reg <= S_NB;
                        end
                        KIND_OWN:
                            state_reg <= (count_reg != 4'd0) ? S_TGT : S_DONE;
                        default:
                        begin
                            if (ec_reg == cols_m2)
                            begin
                                ec_reg <= CW'(1);
                                if (er_reg == rows_m2)
                                    state_reg <= S_DONE;
                                else
                                begin
                                    er_reg    <= er_reg + RW'(1);
                                    state_reg <= S_EV;
                                end
                            end
                            else
                            begin
                                ec_reg    <= ec_reg + CW'(1);
                                state_reg <= S_EV;
                            end
                        end
                    endcase
                end
                S_TGT:
                begin
                    j_reg     <= 3'd0;
                    cum_reg   <= 20'd0;
                    state_reg <= S_ROUL;
                end
                S_ROUL:
                begin
                    cum_reg <= cum_next;
                    if (hit || last)
                    begin
                        pos_row_reg[rbi] <= nr_reg[j_reg];
                        pos_col_reg[rbi] <= nc_reg[j_reg];
                        state_reg        <= S_DONE;
                    end
                    else
                        j_reg <= j_reg + 3'd1;
                end
                S_DONE:
                begin
                    if (cmd_reg == CMD_PLACE && !bad_reg)
                    begin
                        pos_row_reg[rbi] <= place_r;
                        pos_col_reg[rbi] <= place_c;
                    end
                    else if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (bad_reg)
                            m_tdata_reg <= 16'h0000;
                        else if (cmd_reg == CMD_MOVE)
                            m_tdata_reg <= {count_reg, 6'(c0), 6'(r0)};
                        else
                            m_tdata_reg <= {4'd0, 6'(c0), 6'(r0)};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            if (state_reg == S_DONE && cmd_reg == CMD_PLACE && !bad_reg)
                cmd_reg <= CMD_NOP;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'd8)
        else $error("more than eight candidates");
    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:12] <= 4'd8)
        else $error("result count out of range");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mem_we)
        else $error("memory written while idle");
`endif

endmodule
